// ===== src/pit_pkg.sv =====
// ----------------------------------------------------------------------------
// pit_pkg
// Shared constants for the point-in-triangle test pipeline.
// ----------------------------------------------------------------------------
package pit_pkg;

    // Default geometry of the coordinate and weight formats.
    localparam int COORD_BITS_DEF       = 24;
    localparam int COORD_FRAC_BITS_DEF  = 12;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    // Slice width of one partial product in the pipelined multiplier.
    localparam int MUL_CHUNK = 13;

    // Plane tolerance register format (unsigned Q0.24).
    localparam int TOL_BITS      = 24;
    localparam int TOL_FRAC_BITS = 24;

    // Configuration register file.
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_IDX_BITS-1:0] CFG_PLANE_TOL = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AXIS_MAP  = 1'b1;

    localparam logic [TOL_BITS-1:0]      PLANE_TOL_RESET = 24'd1678;
    localparam logic [CFG_DATA_BITS-1:0] AXIS_MAP_RESET  = 24'h412896;

endpackage

// ===== src/pit_delay.sv =====
// ----------------------------------------------------------------------------
// pit_delay
// Enabled shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module pit_delay
    import pit_pkg::*;
#(
    parameter int W = 1,
    parameter int N = 1
)
(
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    generate
        if (N == 0)
        begin : g_pass
            assign dout = din;
        end
        else
        begin : g_line
            logic [W-1:0] tap_reg [N];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tap_reg[0] <= din;
                    for (int i = 1; i < N; i++)
                    begin
                        tap_reg[i] <= tap_reg[i-1];
                    end
                end
            end

            assign dout = tap_reg[N-1];
        end
    endgenerate

endmodule

// ===== src/pit_mul.sv =====
// ----------------------------------------------------------------------------
// pit_mul
// Pipelined signed multiplier, one slice of operand b per stage.
// ----------------------------------------------------------------------------
module pit_mul
    import pit_pkg::*;
#(
    parameter int WA = 25,
    parameter int WB = 25
)
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);

    localparam int NS   = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int WBX  = NS * MUL_CHUNK;
    localparam int WP   = WA + WB;
    localparam int WPP  = WA + MUL_CHUNK + 1;
    localparam int WACC = (WP > WPP) ? WP : WPP;

    logic signed [WA-1:0]   a_reg   [NS];
    logic signed [WBX-1:0]  b_reg   [NS];
    logic signed [WACC-1:0] acc_reg [NS];
    logic signed [WBX-1:0]  b_ext;

    assign b_ext = WBX'(b);

    generate
        for (genvar j = 0; j < NS; j++)
        begin : g_stage
            logic signed [WA-1:0]      a_in;
            logic signed [WBX-1:0]     b_in;
            logic signed [WACC-1:0]    acc_in;
            logic [MUL_CHUNK-1:0]      slice;
            logic signed [MUL_CHUNK:0] slice_s;
            logic signed [WPP-1:0]     pp;
            logic signed [WACC-1:0]    acc_next;

            if (j == 0)
            begin : g_first
                assign a_in   = a;
                assign b_in   = b_ext;
                assign acc_in = '0;
            end
            else
            begin : g_rest
                assign a_in   = a_reg[j-1];
                assign b_in   = b_reg[j-1];
                assign acc_in = acc_reg[j-1];
            end

            // Only the top slice carries the sign of b.
            assign slice   = b_in[j*MUL_CHUNK +: MUL_CHUNK];
            assign slice_s = (j == NS - 1) ? {slice[MUL_CHUNK-1], slice} : {1'b0, slice};

            always_comb
            begin
                pp       = a_in * slice_s;
                acc_next = acc_in + (WACC'(pp) <<< (j * MUL_CHUNK));
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg[j]   <= a_in;
                    b_reg[j]   <= b_in;
                    acc_reg[j] <= acc_next;
                end
            end
        end
    endgenerate

    assign p = acc_reg[NS-1][WP-1:0];

endmodule

// ===== src/pit_div.sv =====
// ----------------------------------------------------------------------------
// pit_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pit_div
    import pit_pkg::*;
#(
    parameter int WN = 51,
    parameter int QB = 17
)
(
    input  logic          clk,
    input  logic          en,
    input  logic [WN-1:0] num,
    input  logic [WN-1:0] den,
    output logic [QB-1:0] quo
);

    logic [WN-1:0] r_reg [QB];
    logic [WN-1:0] d_reg [QB];
    logic [QB-1:0] q_reg [QB];

    generate
        for (genvar j = 0; j < QB; j++)
        begin : g_stage
            logic [WN-1:0] r_in;
            logic [WN-1:0] d_in;
            logic [QB-1:0] q_in;
            logic          ge;

            // The first stage decides the integer bit without doubling.
            if (j == 0)
            begin : g_first
                assign r_in = num;
                assign d_in = den;
                assign q_in = '0;
            end
            else
            begin : g_rest
                assign r_in = {r_reg[j-1][WN-2:0], 1'b0};
                assign d_in = d_reg[j-1];
                assign q_in = q_reg[j-1];
            end

            assign ge = (r_in >= d_in);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[j] <= ge ? (r_in - d_in) : r_in;
                    d_reg[j] <= d_in;
                    q_reg[j] <= {q_in[QB-2:0], ge};
                end
            end
        end
    endgenerate

    assign quo = q_reg[QB-1];

endmodule

// ===== src/point_in_triangle_test_core.sv =====
// ----------------------------------------------------------------------------
// point_in_triangle_test_core
// Streaming point-in-triangle test with barycentric weights.
// ----------------------------------------------------------------------------
// An item is a query point and three vertices, signed fixed-point coordinates.
// It is taken on the input channel when in_valid is high and in_stall is low.
// Each item gives exactly one result item (inside_res, s_weight, t_weight) on
// the output channel, taken when out_valid is high and out_stall is low.
// The datapath is one fully pipelined chain: one item enters per cycle while
// no result is held by out_stall. The longest branch is the projection, the
// axis select and the 17-stage quotient divider; the plane test runs in
// parallel through sliced multipliers.
// When the receiver stalls a waiting result, the whole pipeline freezes and
// in_stall is raised in the same cycle; nothing is lost or repeated.
// Reset clears the valid bits of every stage and loads the configuration
// registers with their defaults. The configuration channel is always ready;
// write it only while no item is in flight.
// ----------------------------------------------------------------------------
module point_in_triangle_test_core
    import pit_pkg::*;
#(
    parameter int COORD_BITS       = COORD_BITS_DEF,
    parameter int COORD_FRAC_BITS  = COORD_FRAC_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_BITS-1:0]  point_x,
    input  logic signed [COORD_BITS-1:0]  point_y,
    input  logic signed [COORD_BITS-1:0]  point_z,
    input  logic signed [COORD_BITS-1:0]  vert0_x,
    input  logic signed [COORD_BITS-1:0]  vert0_y,
    input  logic signed [COORD_BITS-1:0]  vert0_z,
    input  logic signed [COORD_BITS-1:0]  vert1_x,
    input  logic signed [COORD_BITS-1:0]  vert1_y,
    input  logic signed [COORD_BITS-1:0]  vert1_z,
    input  logic signed [COORD_BITS-1:0]  vert2_x,
    input  logic signed [COORD_BITS-1:0]  vert2_y,
    input  logic signed [COORD_BITS-1:0]  vert2_z,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          inside_res,
    output logic [WEIGHT_FRAC_BITS:0]     s_weight,
    output logic [WEIGHT_FRAC_BITS:0]     t_weight,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

    // Datapath widths. Every intermediate is exact.
    localparam int WE   = COORD_BITS + 1;          // edges and point offset
    localparam int WP   = 2 * WE;                  // edge products
    localparam int WN   = WP + 1;                  // normal, numerators
    localparam int WDP  = WN + WE;                 // normal times offset
    localparam int WD   = WDP + 2;                 // plane distance
    localparam int WQP  = 2 * WN;                  // normal squared terms
    localparam int WQ   = WQP + 2;                 // squared normal length
    localparam int WD2  = 2 * WD;                  // squared distance
    localparam int WTOL = TOL_BITS + 1;            // tolerance as signed
    localparam int WNT  = WQ + WTOL;               // length times tolerance
    localparam int WCL  = WD2 + TOL_FRAC_BITS;
    localparam int WCR  = WNT + 2 * COORD_FRAC_BITS;
    localparam int WC   = ((WCL > WCR) ? WCL : WCR) + 1;
    localparam int QB   = WEIGHT_FRAC_BITS + 1;

    // Multiplier latencies, one stage per slice of the second operand.
    localparam int L1 = (WE + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int L2 = (WN + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int L3 = (WD + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int L4 = (WQ + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int LM = (L3 > L4) ? L3 : L4;

    // Stage numbers at which each branch has its registered result.
    localparam int S_SUM      = 3 + L2 + 1;
    localparam int PLANE_DONE = S_SUM + LM + 1;
    localparam int DIV_DONE   = 8 + QB;
    localparam int DONE       = (PLANE_DONE > DIV_DONE) ? PLANE_DONE : DIV_DONE;
    localparam int LAST       = DONE + 1;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [TOL_BITS-1:0]      tol_reg;
    logic [CFG_DATA_BITS-1:0] axis_map_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg      <= PLANE_TOL_RESET;
            axis_map_reg <= AXIS_MAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PLANE_TOL: tol_reg      <= cfg_data[TOL_BITS-1:0];
                CFG_AXIS_MAP:  axis_map_reg <= cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. All stages advance together; the only hold point
    // is a result that the receiver has not taken yet.
    // ------------------------------------------------------------------
    logic            en;
    logic [LAST:1]   vld_reg;
    logic [LAST:1]   vld_next;

    assign en       = !(vld_reg[LAST] && out_stall);
    assign in_stall = !en;
    assign vld_next = {vld_reg[LAST-1:1], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign out_valid = vld_reg[LAST];

    // ------------------------------------------------------------------
    // Stage 1: edges and the point offset from the first vertex.
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] p_in  [3];
    logic signed [COORD_BITS-1:0] v0_in [3];
    logic signed [COORD_BITS-1:0] v1_in [3];
    logic signed [COORD_BITS-1:0] v2_in [3];

    assign p_in  = '{point_x, point_y, point_z};
    assign v0_in = '{vert0_x, vert0_y, vert0_z};
    assign v1_in = '{vert1_x, vert1_y, vert1_z};
    assign v2_in = '{vert2_x, vert2_y, vert2_z};

    logic signed [WE-1:0] e1_s1_reg [3];
    logic signed [WE-1:0] e2_s1_reg [3];
    logic signed [WE-1:0] pv_s1_reg [3];
    logic signed [WE-1:0] e1_s2_reg [3];
    logic signed [WE-1:0] e2_s2_reg [3];
    logic signed [WE-1:0] pv_s2_reg [3];
    logic signed [WE-1:0] e1_s3_reg [3];
    logic signed [WE-1:0] e2_s3_reg [3];
    logic signed [WE-1:0] pv_s3_reg [3];
    logic signed [WE-1:0] e1_s4_reg [3];
    logic signed [WE-1:0] e2_s4_reg [3];
    logic signed [WE-1:0] pv_s4_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_s1_reg[k] <= WE'(v1_in[k]) - WE'(v0_in[k]);
                e2_s1_reg[k] <= WE'(v2_in[k]) - WE'(v0_in[k]);
                pv_s1_reg[k] <= WE'(p_in[k])  - WE'(v0_in[k]);
                e1_s2_reg[k] <= e1_s1_reg[k];
                e2_s2_reg[k] <= e2_s1_reg[k];
                pv_s2_reg[k] <= pv_s1_reg[k];
                e1_s3_reg[k] <= e1_s2_reg[k];
                e2_s3_reg[k] <= e2_s2_reg[k];
                pv_s3_reg[k] <= pv_s2_reg[k];
                e1_s4_reg[k] <= e1_s3_reg[k];
                e2_s4_reg[k] <= e2_s3_reg[k];
                pv_s4_reg[k] <= pv_s3_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 and 3: the cross-product normal.
    // ------------------------------------------------------------------
    logic signed [WP-1:0] cp_reg [6];
    logic signed [WN-1:0] n_reg  [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cp_reg[0] <= e1_s1_reg[1] * e2_s1_reg[2];
            cp_reg[1] <= e2_s1_reg[1] * e1_s1_reg[2];
            cp_reg[2] <= e1_s1_reg[2] * e2_s1_reg[0];
            cp_reg[3] <= e2_s1_reg[2] * e1_s1_reg[0];
            cp_reg[4] <= e2_s1_reg[1] * e1_s1_reg[0];
            cp_reg[5] <= e1_s1_reg[1] * e2_s1_reg[0];
            n_reg[0]  <= WN'(cp_reg[0]) - WN'(cp_reg[1]);
            n_reg[1]  <= WN'(cp_reg[2]) - WN'(cp_reg[3]);
            n_reg[2]  <= WN'(cp_reg[4]) - WN'(cp_reg[5]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: dominant normal axis and its sign pick the slot of the axis
    // map. Ties go to the higher axis; index 3 saturates to axis 2.
    // ------------------------------------------------------------------
    logic [WN-1:0] mag [3];
    logic [1:0]    axis;
    logic          axis_pos;
    logic [2:0]    slot;
    logic [3:0]    nib;
    logic [1:0]    k0_next;
    logic [1:0]    k1_next;
    logic [1:0]    k0_reg;
    logic [1:0]    k1_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = n_reg[k][WN-1] ? WN'(-n_reg[k]) : WN'(n_reg[k]);
        end
        priority if ((mag[2] >= mag[1]) && (mag[2] >= mag[0]))
        begin
            axis = 2'd2;
        end
        else if (mag[1] >= mag[0])
        begin
            axis = 2'd1;
        end
        else
        begin
            axis = 2'd0;
        end
        axis_pos = !n_reg[axis][WN-1] && (n_reg[axis] != '0);
        slot     = {axis, 1'b0} + {2'b00, axis_pos};
        nib      = axis_map_reg[{slot, 2'b00} +: 4];
        k0_next  = (nib[1:0] == 2'd3) ? 2'd2 : nib[1:0];
        k1_next  = (nib[3:2] == 2'd3) ? 2'd2 : nib[3:2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k0_reg <= k0_next;
            k1_reg <= k1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 5 to 8: project onto the kept axes, form the barycentric
    // numerators and the denominator, then the inside test.
    // ------------------------------------------------------------------
    logic signed [WE-1:0] pk0_reg, pk1_reg, ak0_reg, ak1_reg, bk0_reg, bk1_reg;
    logic signed [WP-1:0] jp_reg [6];
    logic signed [WN-1:0] nt_reg, ns_reg, den_reg;
    logic signed [WN-1:0] nt_s8_reg, ns_s8_reg, den_s8_reg;
    logic                 proj_ok_reg;
    logic signed [WN:0]   num_sum;
    logic                 proj_ok_next;

    always_comb
    begin
        num_sum      = (WN+1)'(ns_reg) + (WN+1)'(nt_reg);
        proj_ok_next = !nt_reg[WN-1] && !ns_reg[WN-1] && !den_reg[WN-1]
                       && (den_reg != '0) && (num_sum <= (WN+1)'(den_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pk0_reg     <= pv_s4_reg[k0_reg];
            pk1_reg     <= pv_s4_reg[k1_reg];
            ak0_reg     <= e1_s4_reg[k0_reg];
            ak1_reg     <= e1_s4_reg[k1_reg];
            bk0_reg     <= e2_s4_reg[k0_reg];
            bk1_reg     <= e2_s4_reg[k1_reg];
            jp_reg[0]   <= pk1_reg * ak0_reg;
            jp_reg[1]   <= ak1_reg * pk0_reg;
            jp_reg[2]   <= bk1_reg * pk0_reg;
            jp_reg[3]   <= pk1_reg * bk0_reg;
            jp_reg[4]   <= bk1_reg * ak0_reg;
            jp_reg[5]   <= ak1_reg * bk0_reg;
            nt_reg      <= WN'(jp_reg[0]) - WN'(jp_reg[1]);
            ns_reg      <= WN'(jp_reg[2]) - WN'(jp_reg[3]);
            den_reg     <= WN'(jp_reg[4]) - WN'(jp_reg[5]);
            nt_s8_reg   <= nt_reg;
            ns_s8_reg   <= ns_reg;
            den_s8_reg  <= den_reg;
            proj_ok_reg <= proj_ok_next;
        end
    end

    // Weights: (numerator << WEIGHT_FRAC_BITS) / denominator, truncated.
    logic [QB-1:0] qs_raw, qt_raw, qs_al, qt_al;
    logic          proj_ok_al;

    pit_div #(.WN(WN), .QB(QB)) u_div_s
    (
        .clk (clk),
        .en  (en),
        .num (ns_s8_reg),
        .den (den_s8_reg),
        .quo (qs_raw)
    );

    pit_div #(.WN(WN), .QB(QB)) u_div_t
    (
        .clk (clk),
        .en  (en),
        .num (nt_s8_reg),
        .den (den_s8_reg),
        .quo (qt_raw)
    );

    pit_delay #(.W(2 * QB), .N(DONE - DIV_DONE)) u_dly_q
    (
        .clk  (clk),
        .en   (en),
        .din  ({qs_raw, qt_raw}),
        .dout ({qs_al, qt_al})
    );

    pit_delay #(.W(1), .N(DONE - 8)) u_dly_ok
    (
        .clk  (clk),
        .en   (en),
        .din  (proj_ok_reg),
        .dout (proj_ok_al)
    );

    // ------------------------------------------------------------------
    // Plane test: (n . offset)^2 against tolerance * |n|^2, exact.
    // ------------------------------------------------------------------
    logic signed [WDP-1:0] dp_raw [3];
    logic signed [WDP-1:0] dp_al  [3];
    logic signed [WQP-1:0] nq     [3];
    logic signed [WD-1:0]  dist_reg;
    logic signed [WQ-1:0]  nsq_reg;
    logic signed [WD2-1:0] d2_raw, d2;
    logic signed [WNT-1:0] ntol_raw, ntol_al;
    logic signed [WTOL-1:0] tol_s;
    logic signed [WC-1:0]  lhs, rhs;
    logic                  off_reg;
    logic                  off_al;

    generate
        for (genvar k = 0; k < 3; k++)
        begin : g_plane
            pit_mul #(.WA(WN), .WB(WE)) u_mul_dp
            (
                .clk (clk),
                .en  (en),
                .a   (n_reg[k]),
                .b   (pv_s3_reg[k]),
                .p   (dp_raw[k])
            );

            pit_delay #(.W(WDP), .N(L2 - L1)) u_dly_dp
            (
                .clk  (clk),
                .en   (en),
                .din  (dp_raw[k]),
                .dout (dp_al[k])
            );

            pit_mul #(.WA(WN), .WB(WN)) u_mul_nq
            (
                .clk (clk),
                .en  (en),
                .a   (n_reg[k]),
                .b   (n_reg[k]),
                .p   (nq[k])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= WD'(dp_al[0]) + WD'(dp_al[1]) + WD'(dp_al[2]);
            nsq_reg  <= WQ'(nq[0]) + WQ'(nq[1]) + WQ'(nq[2]);
        end
    end

    assign tol_s = $signed({1'b0, tol_reg});

    pit_mul #(.WA(WD), .WB(WD)) u_mul_d2
    (
        .clk (clk),
        .en  (en),
        .a   (dist_reg),
        .b   (dist_reg),
        .p   (d2_raw)
    );

    pit_delay #(.W(WD2), .N(LM - L3)) u_dly_d2
    (
        .clk  (clk),
        .en   (en),
        .din  (d2_raw),
        .dout (d2)
    );

    // The narrow tolerance is the full-width operand, so the long squared
    // length is the one cut into slices.
    pit_mul #(.WA(WTOL), .WB(WQ)) u_mul_tol
    (
        .clk (clk),
        .en  (en),
        .a   (tol_s),
        .b   (nsq_reg),
        .p   (ntol_raw)
    );

    pit_delay #(.W(WNT), .N(LM - L4)) u_dly_tol
    (
        .clk  (clk),
        .en   (en),
        .din  (ntol_raw),
        .dout (ntol_al)
    );

    // Equality counts as off the plane, which also rejects a zero normal.
    always_comb
    begin
        lhs = WC'(d2) <<< TOL_FRAC_BITS;
        rhs = WC'(ntol_al) <<< (2 * COORD_FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            off_reg <= (lhs >= rhs);
        end
    end

    pit_delay #(.W(1), .N(DONE - PLANE_DONE)) u_dly_off
    (
        .clk  (clk),
        .en   (en),
        .din  (off_reg),
        .dout (off_al)
    );

    // ------------------------------------------------------------------
    // Output register: outside points report zero weights.
    // ------------------------------------------------------------------
    logic inside_next;

    assign inside_next = proj_ok_al && !off_al;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_res <= inside_next;
            s_weight   <= inside_next ? qs_al : '0;
            t_weight   <= inside_next ? qt_al : '0;
        end
    end

endmodule
